FILE: rtl/core/grc_pkg.sv
package grc_pkg;

	// divider operand widths
	localparam int DIV_NW = 50;
	localparam int DIV_DW = 46;
	localparam int DIV_CW = $clog2(DIV_NW);

	// world units per map cell, a power of two so cell and offset are a shift and a mask
	localparam int TILE_SIZE = 64;
	localparam int TILE_SH   = 8 + $clog2(TILE_SIZE);

	localparam int POS_W   = 24;
	localparam int VEC_W   = 16;
	localparam int SCR_W   = 12;
	localparam int COL_W   = 11;
	localparam int CAM_W   = 28;
	localparam int PROD_W  = VEC_W + CAM_W;
	localparam int RAY_W   = 31;
	localparam int MX_W    = 18;
	localparam int FRAC_W  = 19;
	localparam int DELTA_W = 32;
	localparam int SD_W    = 46;
	localparam int LH_W    = 28;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 24;

	localparam int CAM_OFS = 16384;
	localparam logic [DELTA_W-1:0] DIST_MAX = '1;
	localparam logic [SD_W-1:0] MIN_DIST = SD_W'(7);
	localparam logic [COL_W-1:0] OUT_MAX = '1;

	localparam logic [VEC_W-1:0] RST_DIR_X   = VEC_W'(16384);
	localparam logic [VEC_W-1:0] RST_DIR_Y   = '0;
	localparam logic [VEC_W-1:0] RST_PLANE_X = '0;
	localparam logic [VEC_W-1:0] RST_PLANE_Y = VEC_W'(10813);
	localparam logic [SCR_W-1:0] RST_WIDTH   = SCR_W'(640);
	localparam logic [SCR_W-1:0] RST_HEIGHT  = SCR_W'(480);

	localparam logic [CFG_IW-1:0] REG_POS_X   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_POS_Y   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DIR_X   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DIR_Y   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_PLANE_X = 3'd4;
	localparam logic [CFG_IW-1:0] REG_PLANE_Y = 3'd5;
	localparam logic [CFG_IW-1:0] REG_WIDTH   = 3'd6;
	localparam logic [CFG_IW-1:0] REG_HEIGHT  = 3'd7;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_CAST  = 1'b1;

	typedef enum logic [1:0] {
		DOP_CAM, DOP_DX, DOP_DY, DOP_LH
	} div_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DIV_CAM, ST_MUL_RAY, ST_RAY,
		ST_DIV_DX, ST_DIV_DY, ST_MUL_SIDE, ST_STEP,
		ST_READ, ST_TEST, ST_PERP, ST_DIV_LH, ST_OUT
	} state_t;

	typedef struct packed {
		logic    in_ready;
		logic    take_col;
		logic    map_wr;
		logic    clr_wr;
		logic    div_start;
		div_op_t div_op;
		logic    mul_ray;
		logic    ray;
		logic    mul_side;
		logic    step;
		logic    rd_en;
		logic    perp;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_mode;
		logic clr_last;
		logic div_done;
		logic hit;
		logic steps_done;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/core/grc_in_if.sv
interface grc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [10:0] column;
	logic [4:0] cell_x;
	logic [4:0] cell_y;
	logic [7:0] cell_value;

	modport source(output valid, mode, column, cell_x, cell_y, cell_value, input ready);
	modport sink(input valid, mode, column, cell_x, cell_y, cell_value, output ready);
endinterface

FILE: rtl/core/grc_out_if.sv
interface grc_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] out_column;
	logic [10:0] span_start;
	logic [10:0] span_end;
	logic        side_hit;
	logic        wall_found;

	modport source(output valid, out_column, span_start, span_end, side_hit, wall_found,
		input ready);
	modport sink(input valid, out_column, span_start, span_end, side_hit, wall_found,
		output ready);
endinterface

FILE: rtl/core/grc_div.sv
module grc_div
	import grc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo,
	output logic [DIV_DW-1:0] rem
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   sh;
	logic              ge;

	always_comb begin
		sh = {rem_q, quo_q[DIV_NW-1]};
		ge = sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(sh - {1'b0, den_q}) : sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/grc_datapath.sv
module grc_datapath
	import grc_pkg::*;
#(
	parameter int MAP_WIDTH  = 32,
	parameter int MAP_HEIGHT = 32,
	parameter int MAX_STEPS  = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	grc_in_if.sink            cast_in,
	grc_out_if.source         span_out,
	input  cmd_t              cmd,
	output sts_t              sts
);

	localparam int MAP_N = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(MAP_N);
	localparam int NW    = $clog2(MAX_STEPS + 1);
	localparam logic [FRAC_W-1:0] TILE_D = FRAC_W'(256 * TILE_SIZE);

	// configuration registers
	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [SCR_W-1:0]        width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			dir_x_q   <= RST_DIR_X;
			dir_y_q   <= RST_DIR_Y;
			plane_x_q <= RST_PLANE_X;
			plane_y_q <= RST_PLANE_Y;
			width_q   <= RST_WIDTH;
			height_q  <= RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data;
				REG_POS_Y:   pos_y_q   <= cfg_data;
				REG_DIR_X:   dir_x_q   <= cfg_data[VEC_W-1:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[VEC_W-1:0];
				REG_PLANE_X: plane_x_q <= cfg_data[VEC_W-1:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[VEC_W-1:0];
				REG_WIDTH:   width_q   <= cfg_data[SCR_W-1:0];
				REG_HEIGHT:  height_q  <= cfg_data[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SCR_W-1:0] w_eff, h_eff;
	assign w_eff = (width_q == '0) ? SCR_W'(1) : width_q;
	assign h_eff = (height_q == '0) ? SCR_W'(1) : height_q;

	// working registers
	logic [COL_W-1:0]         col_q;
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1;
	logic                     neg_x_q, neg_y_q;
	logic [RAY_W-1:0]         mag_x_q, mag_y_q;
	logic signed [MX_W-1:0]   mx_q, my_q;
	logic [FRAC_W-1:0]        frac_x_q, frac_y_q;
	logic [DELTA_W-1:0]       dx_q, dy_q;
	logic [SD_W-1:0]          sdx_q, sdy_q;
	logic [NW-1:0]            n_q;
	logic                     side_q;
	logic                     oob_q, rd_q;
	logic [SD_W-1:0]          perp_q;
	logic [LH_W-1:0]          lh_q;
	div_op_t                  op_q;

	// divider
	logic              div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den, div_rem;

	always_comb begin
		case (cmd.div_op)
			DOP_CAM: begin
				div_num = DIV_NW'({col_q, 15'b0});
				div_den = DIV_DW'(w_eff);
			end
			DOP_DX: begin
				div_num = DIV_NW'(1) << 30;
				div_den = DIV_DW'(mag_x_q);
			end
			DOP_DY: begin
				div_num = DIV_NW'(1) << 30;
				div_den = DIV_DW'(mag_y_q);
			end
			default: begin
				div_num = DIV_NW'({h_eff, 16'b0});
				div_den = perp_q;
			end
		endcase
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	logic [DELTA_W-1:0] delta_sat;
	assign delta_sat = (|div_quo[DIV_NW-1:DELTA_W]) ? DIST_MAX : div_quo[DELTA_W-1:0];

	// ray components
	logic signed [RAY_W-1:0] ray_x, ray_y;
	assign ray_x = RAY_W'(dir_x_q) + RAY_W'(prod_x_s1 >>> 14);
	assign ray_y = RAY_W'(dir_y_q) + RAY_W'(prod_y_s1 >>> 14);

	logic [FRAC_W-1:0] dist_x, dist_y;
	assign dist_x = neg_x_q ? frac_x_q : TILE_D - frac_x_q;
	assign dist_y = neg_y_q ? frac_y_q : TILE_D - frac_y_q;

	logic          go_x;
	logic [SD_W-1:0] perp_raw;
	assign go_x     = sdx_q < sdy_q;
	assign perp_raw = side_q ? sdy_q - SD_W'(dy_q) : sdx_q - SD_W'(dx_q);

	always_ff @(posedge clk) begin
		if (cmd.take_col) begin
			col_q  <= cast_in.column;
			n_q    <= '0;
			side_q <= 1'b0;
		end
		if (cmd.div_start)
			op_q <= cmd.div_op;
		if (div_done) begin
			case (op_q)
				DOP_CAM: cam_q <= CAM_W'(div_quo[26:0]) - CAM_W'(CAM_OFS);
				DOP_DX:  dx_q  <= delta_sat;
				DOP_DY:  dy_q  <= delta_sat;
				default: lh_q  <= div_quo[LH_W-1:0];
			endcase
		end
		if (cmd.mul_ray) begin
			prod_x_s1 <= plane_x_q * cam_q;
			prod_y_s1 <= plane_y_q * cam_q;
		end
		if (cmd.ray) begin
			neg_x_q  <= ray_x[RAY_W-1];
			neg_y_q  <= ray_y[RAY_W-1];
			mag_x_q  <= ray_x[RAY_W-1] ? RAY_W'(-ray_x) : RAY_W'(ray_x);
			mag_y_q  <= ray_y[RAY_W-1] ? RAY_W'(-ray_y) : RAY_W'(ray_y);
			mx_q     <= MX_W'(pos_x_q >> TILE_SH);
			my_q     <= MX_W'(pos_y_q >> TILE_SH);
			frac_x_q <= FRAC_W'(pos_x_q[TILE_SH-1:0]);
			frac_y_q <= FRAC_W'(pos_y_q[TILE_SH-1:0]);
		end
		// scale the edge offset by the step length, back to cell units
		if (cmd.mul_side) begin
			sdx_q <= SD_W'((DIV_NW'(dist_x) * DIV_NW'(dx_q)) >> TILE_SH);
			sdy_q <= SD_W'((DIV_NW'(dist_y) * DIV_NW'(dy_q)) >> TILE_SH);
		end
		if (cmd.step) begin
			n_q <= n_q + 1'b1;
			if (go_x) begin
				sdx_q  <= sdx_q + SD_W'(dx_q);
				mx_q   <= neg_x_q ? mx_q - 1'b1 : mx_q + 1'b1;
				side_q <= 1'b0;
			end else begin
				sdy_q  <= sdy_q + SD_W'(dy_q);
				my_q   <= neg_y_q ? my_q - 1'b1 : my_q + 1'b1;
				side_q <= 1'b1;
			end
		end
		if (cmd.rd_en)
			oob_q <= (mx_q < 0) || (mx_q >= MX_W'(MAP_WIDTH))
				|| (my_q < 0) || (my_q >= MX_W'(MAP_HEIGHT));
		if (cmd.perp)
			perp_q <= (perp_raw < MIN_DIST) ? MIN_DIST : perp_raw;
	end

	// tile map, one wall bit per cell
	logic            map_mem [MAP_N];
	logic [AW-1:0]   clr_q;
	logic [16:0]     wr_lin, rd_lin;
	logic            wr_in_map;

	assign wr_lin = 17'(cast_in.cell_y) * 17'(MAP_WIDTH) + 17'(cast_in.cell_x);
	assign rd_lin = 17'(my_q[7:0]) * 17'(MAP_WIDTH) + 17'(mx_q[7:0]);
	assign wr_in_map = (int'(cast_in.cell_x) < MAP_WIDTH) && (int'(cast_in.cell_y) < MAP_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_wr)
			clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			map_mem[clr_q] <= 1'b0;
		else if (cmd.map_wr && wr_in_map)
			map_mem[wr_lin[AW-1:0]] <= (cast_in.cell_value == 8'd1);
		if (cmd.rd_en)
			rd_q <= map_mem[rd_lin[AW-1:0]];
	end

	// span from line height
	logic [10:0]     half_h;
	logic [LH_W-2:0] half_lh;
	logic [COL_W-1:0] start_v, end_v;
	logic [LH_W:0]   end_sum, end_c;

	always_comb begin
		half_h  = h_eff[SCR_W-1:1];
		half_lh = lh_q[LH_W-1:1];
		start_v = (LH_W'(half_lh) >= LH_W'(half_h)) ? '0 : half_h - half_lh[10:0];
		end_sum = (LH_W+1)'(half_h) + (LH_W+1)'(half_lh);
		end_c   = (end_sum >= (LH_W+1)'(h_eff)) ? (LH_W+1)'(h_eff - 1'b1) : end_sum;
		end_v   = (end_c > (LH_W+1)'(OUT_MAX)) ? OUT_MAX : end_c[COL_W-1:0];
	end

	// output word register
	logic             out_valid_q;
	logic [COL_W-1:0] out_col_q, out_start_q, out_end_q;
	logic             out_side_q, out_wall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (span_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_col_q   <= col_q;
			out_start_q <= start_v;
			out_end_q   <= end_v;
			out_side_q  <= side_q;
			out_wall_q  <= oob_q | rd_q;
		end
	end

	assign span_out.valid      = out_valid_q;
	assign span_out.out_column = out_col_q;
	assign span_out.span_start = out_start_q;
	assign span_out.span_end   = out_end_q;
	assign span_out.side_hit   = out_side_q;
	assign span_out.wall_found = out_wall_q;
	assign cast_in.ready       = cmd.in_ready;

	always_comb begin
		sts.in_valid   = cast_in.valid;
		sts.in_mode    = cast_in.mode;
		sts.clr_last   = (clr_q == AW'(MAP_N - 1));
		sts.div_done   = div_done;
		sts.hit        = oob_q | rd_q;
		sts.steps_done = (n_q == NW'(MAX_STEPS));
		sts.out_free   = !out_valid_q || span_out.ready;
	end

endmodule

FILE: rtl/core/grc_ctrl.sv
module grc_ctrl
	import grc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   issued_q, issued_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= issued_d;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.div_op = DOP_CAM;
		state_d  = state_q;
		issued_d = issued_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					if (sts.in_mode == MODE_CAST) begin
						cmd.take_col = 1'b1;
						state_d = ST_DIV_CAM;
					end else begin
						cmd.map_wr = 1'b1;
					end
				end
			end
			ST_MUL_RAY: begin
				cmd.mul_ray = 1'b1;
				state_d = ST_RAY;
			end
			ST_RAY: begin
				cmd.ray = 1'b1;
				state_d = ST_DIV_DX;
			end
			ST_MUL_SIDE: begin
				cmd.mul_side = 1'b1;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (sts.hit || sts.steps_done)
					state_d = ST_PERP;
				else
					state_d = ST_STEP;
			end
			ST_PERP: begin
				cmd.perp = 1'b1;
				state_d = ST_DIV_LH;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIV_CAM, ST_DIV_DX, ST_DIV_DY, ST_DIV_LH: begin
				unique case (state_q)
					ST_DIV_CAM: cmd.div_op = DOP_CAM;
					ST_DIV_DX:  cmd.div_op = DOP_DX;
					ST_DIV_DY:  cmd.div_op = DOP_DY;
					default:    cmd.div_op = DOP_LH;
				endcase
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_d = 1'b1;
				end else if (sts.div_done) begin
					issued_d = 1'b0;
					unique case (state_q)
						ST_DIV_CAM: state_d = ST_MUL_RAY;
						ST_DIV_DX:  state_d = ST_DIV_DY;
						ST_DIV_DY:  state_d = ST_MUL_SIDE;
						default:    state_d = ST_OUT;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/core/grid_raycast_column_unit.sv
// Column wall-span unit for a grid ray walk.
// cast_in carries one word per item: mode 0 stores a map cell (wall when the
// value is 1), mode 1 casts one screen column. A cast returns one word on
// span_out with the clamped wall span, the side of the last step and a hit
// flag; a cell write returns nothing.
// Configuration goes in through cfg_we / cfg_index / cfg_data; the user must
// write it only while idle, which the block itself does not enforce. A cell
// write is stored as it is accepted. A cast runs four divisions (column
// offset, two step lengths, line height) on one shared restoring divider,
// five setup and finish states, then a step, map read and test state per
// grid cell crossed; the walk is bounded by MAX_STEPS.
// The unit takes one item at a time; cast_in.ready is high only while idle.
// The finished word sits in an output register, so a new item is taken while
// span_out is stalled; a second cast waits at its end until that word leaves.
// After reset the map is cleared, one cell per cycle across all MAP_WIDTH *
// MAP_HEIGHT cells, with cast_in.ready low; configuration writes still land.
module grid_raycast_column_unit
	import grc_pkg::*;
#(
	parameter int MAP_WIDTH  = 32,
	parameter int MAP_HEIGHT = 32,
	parameter int MAX_STEPS  = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	grc_in_if.sink            cast_in,
	grc_out_if.source         span_out
);

	cmd_t cmd;
	sts_t sts;

	grc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	grc_datapath #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT),
		.MAX_STEPS  (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cast_in   (cast_in),
		.span_out  (span_out),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: test/tb_grid_raycast_column_unit.sv
`timescale 1ns / 1ps

module tb_grid_raycast_column_unit;
	import grc_pkg::*;

	typedef struct packed {
		logic [10:0] col;
		logic [10:0] start;
		logic [10:0] stop;
		logic        side;
		logic        hit;
	} span_t;

	typedef struct {
		logic        mode;
		logic [10:0] col;
		logic [4:0]  cx;
		logic [4:0]  cy;
		logic [7:0]  val;
		bit          typed;
		span_t       want;
	} row_t;

	localparam int MAP_W = 32;
	localparam int MAP_H = 32;
	localparam int TILE = 64;
	localparam int STEP_LIMIT = 2048;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	grc_in_if  in_bus();
	grc_out_if out_bus();

	grid_raycast_column_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cast_in(in_bus), .span_out(out_bus)
	);

	// shadow of the block state
	logic [7:0]         tiles [0:MAP_W*MAP_H-1];
	logic [23:0]        view_px, view_py;
	logic signed [15:0] view_dx, view_dy, view_plx, view_ply;
	logic [11:0]        scr_w, scr_h;

	span_t spans_due [$];
	int    errs = 0;
	int    casts = 0;
	int    writes = 0;
	int    spans_seen = 0;
	bit    calm = 0;
	row_t  rows [$];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("timeout at %0t", $time);
		$display("tb_grid_raycast_column_unit NOT OK");
		$finish;
	end

	function automatic void view_apply(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] v);
		case (idx)
			REG_POS_X:   view_px = v;
			REG_POS_Y:   view_py = v;
			REG_DIR_X:   view_dx = v[15:0];
			REG_DIR_Y:   view_dy = v[15:0];
			REG_PLANE_X: view_plx = v[15:0];
			REG_PLANE_Y: view_ply = v[15:0];
			REG_WIDTH:   scr_w = v[11:0];
			REG_HEIGHT:  scr_h = v[11:0];
			default: ;
		endcase
	endfunction

	task automatic axis_start(input longint pos, input longint ray, output longint grid_pos,
		output longint dir, output longint delta, output longint side);
		longint d;
		longint frac;
		longint mag;
		d = 256 * TILE;
		frac = pos % d;
		mag = ray < 0 ? -ray : ray;
		grid_pos = pos / d;
		delta = (mag == 0) ? 64'hFFFF_FFFF : ((64'sd1 << 30) / mag);
		if (delta > 64'hFFFF_FFFF) delta = 64'hFFFF_FFFF;
		if (ray < 0) begin
			dir = -1;
			side = frac * delta / d;
		end else begin
			dir = 1;
			side = (d - frac) * delta / d;
		end
	endtask

	function automatic bit blocked(longint mx, longint my);
		if (mx < 0 || my < 0 || mx >= MAP_W || my >= MAP_H) return 1;
		return tiles[my * MAP_W + mx] == 8'd1;
	endfunction

	task automatic predict_span(input logic [10:0] col, output span_t s);
		longint w, h, cam, rx, ry, mx, my, sx, sy, dx, dy, sdx, sdy, perp, lh, st, en;
		bit hit;
		bit side;
		w = scr_w == 0 ? 1 : scr_w;
		h = scr_h == 0 ? 1 : scr_h;
		cam = (32768 * longint'(col)) / w - 16384;
		// floor division by 2^14 is an arithmetic shift
		rx = longint'(view_dx) + ((longint'(view_plx) * cam) >>> 14);
		ry = longint'(view_dy) + ((longint'(view_ply) * cam) >>> 14);
		axis_start(view_px, rx, mx, sx, dx, sdx);
		axis_start(view_py, ry, my, sy, dy, sdy);
		hit = 0;
		side = 0;
		for (int n = 0; n < STEP_LIMIT && !hit; n++) begin
			if (sdx < sdy) begin
				sdx += dx; mx += sx; side = 0;
			end else begin
				sdy += dy; my += sy; side = 1;
			end
			if (blocked(mx, my)) hit = 1;
		end
		perp = side ? sdy - dy : sdx - dx;
		if (perp < 7) perp = 7;
		lh = (h << 16) / perp;
		st = h / 2 - lh / 2;
		en = h / 2 + lh / 2;
		if (st < 0) st = 0;
		if (en >= h) en = h - 1;
		if (st > 2047) st = 2047;
		if (en > 2047) en = 2047;
		s.col = col;
		s.start = st[10:0];
		s.stop = en[10:0];
		s.side = side;
		s.hit = hit;
	endtask

	task automatic load_view(input logic [23:0] px, input logic [23:0] py,
		input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] plx,
		input logic [15:0] ply, input logic [11:0] w, input logic [11:0] h);
		logic [CFG_DW-1:0] vals [8];
		vals = '{px, py, 24'(dx), 24'(dy), 24'(plx), 24'(ply), 24'(w), 24'(h)};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IW'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			view_apply(CFG_IW'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// hold the sender until every span is back, then let a write settle
	task automatic drain();
		in_bus.valid <= 1'b0;
		@(posedge clk);
		while (spans_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_word(input row_t r);
		span_t s;
		if (!calm)
			while ($urandom_range(99) < 26) begin
				in_bus.valid <= 1'b0;
				@(posedge clk);
			end
		in_bus.valid <= 1'b1;
		in_bus.mode <= r.mode;
		in_bus.column <= r.col;
		in_bus.cell_x <= r.cx;
		in_bus.cell_y <= r.cy;
		in_bus.cell_value <= r.val;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
		if (r.mode == MODE_WRITE) begin
			tiles[r.cy * MAP_W + r.cx] = r.val;
			writes++;
		end else begin
			predict_span(r.col, s);
			spans_due.push_back(r.typed ? r.want : s);
			casts++;
		end
	endtask

	function automatic row_t wr_row(int x, int y, int v);
		row_t r;
		r = '{MODE_WRITE, 11'($urandom), 5'(x), 5'(y), 8'(v), 0, '0};
		return r;
	endfunction

	function automatic row_t cast_row(int c);
		row_t r;
		r = '{MODE_CAST, 11'(c), 5'($urandom), 5'($urandom), 8'($urandom), 0, '0};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				span_t got;
				got = '{out_bus.out_column, out_bus.span_start, out_bus.span_end,
					out_bus.side_hit, out_bus.wall_found};
				spans_seen++;
				if (spans_due.size() == 0) begin
					errs++;
					$display("%0t: span word with nothing due: %p", $time, got);
				end else begin
					span_t want;
					want = spans_due.pop_front();
					if (got !== want) begin
						errs++;
						$display("%0t: span mismatch expected %p actual %p", $time, want, got);
					end
				end
			end
			out_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
		end
	end

	initial begin
		row_t r;
		row_t t;
		int w;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_bus.valid = 0;
		in_bus.mode = MODE_WRITE;
		in_bus.column = '0;
		in_bus.cell_x = '0;
		in_bus.cell_y = '0;
		in_bus.cell_value = '0;
		foreach (tiles[i]) tiles[i] = '0;
		view_px = '0; view_py = '0;
		view_dx = RST_DIR_X; view_dy = RST_DIR_Y;
		view_plx = RST_PLANE_X; view_ply = RST_PLANE_Y;
		scr_w = RST_WIDTH; scr_h = RST_HEIGHT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset view, walls right next to the start cell
		rows.push_back(wr_row(1, 0, 1));
		rows.push_back(wr_row(0, 1, 1));
		rows.push_back(wr_row(31, 31, 255));
		rows.push_back(wr_row(31, 0, 0));
		t = cast_row(320);
		t.typed = 1;
		t.want = '{11'd320, 11'd0, 11'd479, 1'b0, 1'b1};
		rows.push_back(t);
		rows.push_back(cast_row(0));
		rows.push_back(cast_row(639));
		rows.push_back(cast_row(2047));
		rows.push_back(wr_row(0, 0, 1));
		rows.push_back(cast_row(1));
		rows.push_back(wr_row(1, 0, 0));
		rows.push_back(cast_row(320));
		rows.push_back(wr_row(1, 0, 2));
		rows.push_back(cast_row(100));
		rows.push_back(cast_row(1023));
		foreach (rows[i]) send_word(rows[i]);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: load_view(24'd0, 24'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 12'd0, 12'd0);
				1: load_view(24'hFFFFFF, 24'hFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
					12'hFFF, 12'hFFF);
				2: load_view(24'h048000, 24'h028123, 16'h4000, 16'h0000, 16'h0000, 16'h2A3D,
					12'd1, 12'd1);
				3: load_view(24'h03FFFF, 24'h040000, 16'h0000, 16'hC000, 16'h2A3D, 16'h0000,
					12'd2048, 12'd2048);
				default: load_view(24'($urandom_range(0, 32 * 16384 - 1)),
					24'($urandom_range(0, 32 * 16384 - 1)), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 12'($urandom_range(1, 2048)),
					12'($urandom_range(1, 2048)));
			endcase
			calm = (ph == 3);
			w = scr_w == 0 ? 1 : scr_w;
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(99) < 35)
					r = wr_row($urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(99) < 20 ? 1 : $urandom_range(0, 255));
				else
					r = cast_row($urandom_range(9) < 8 ? $urandom_range(0, w - 1)
						: $urandom_range(0, 2047));
				send_word(r);
			end
			drain();
		end
		calm = 0;

		repeat (50) @(posedge clk);
		if (spans_due.size() != 0) begin
			errs++;
			$display("%0t: %0d spans never came", $time, spans_due.size());
		end
		$display("%0d casts, %0d map writes, %0d spans checked over 8 views", casts, writes,
			spans_seen);
		if (errs == 0)
			$display("tb_grid_raycast_column_unit OK");
		else
			$display("tb_grid_raycast_column_unit NOT OK");
		$finish;
	end

endmodule
